// ----- design/ghash_pkg.sv -----
// ghash_pkg: types, command codes and GF(2^128) helper functions for the GHASH accumulator.
// No dependencies; imported by ghash_front, ghash_back and the top level.

package ghash_pkg;

	localparam int BLK_W   = 128;
	localparam int DIGIT_W = 8;
	localparam int DIGITS  = BLK_W / DIGIT_W;
	localparam int DIG_CW  = $clog2(DIGITS);

	// input commands
	localparam logic [1:0] CMD_ABSORB = 2'd0;
	localparam logic [1:0] CMD_FINAL  = 2'd1;
	localparam logic [1:0] CMD_LOAD   = 2'd2;

	// work kinds handed from front to back
	localparam logic [1:0] WK_READ    = 2'd0;
	localparam logic [1:0] WK_LOAD    = 2'd1;
	localparam logic [1:0] WK_MUL_UPD = 2'd2;
	localparam logic [1:0] WK_MUL_TAG = 2'd3;

	// reduction constant, reflected: 0xE1 followed by 120 zero bits
	localparam logic [BLK_W-1:0] GF_R = {64'hE100_0000_0000_0000, 64'h0};

	typedef struct packed {
		logic [1:0]  cmd;
		logic [63:0] data_hi;
		logic [63:0] data_lo;
		logic [4:0]  byte_count;
		logic [60:0] aad_bytes;
		logic [60:0] ct_bytes;
	} in_t;

	typedef struct packed {
		logic [63:0] hash_hi;
		logic [63:0] hash_lo;
		logic        is_tag;
	} out_t;

	typedef struct packed {
		logic [1:0]       kind;
		logic [BLK_W-1:0] operand;
	} work_t;

	typedef struct packed {
		logic [BLK_W-1:0] acc;
		logic [BLK_W-1:0] v;
	} gf_st_t;

	// keep bytes 0..cnt-1 (byte 0 most significant); counts of 16 and up keep all
	function automatic logic [BLK_W-1:0] byte_mask(input logic [4:0] cnt);
		logic [BLK_W-1:0] m;
		int i;
		m = '0;
		for (i = 0; i < BLK_W / 8; i++) begin
			if (5'(i) < cnt) m[BLK_W-1-8*i -: 8] = 8'hFF;
		end
		return m;
	endfunction

	// one digit of the right-shift multiply, most significant operand bit first
	function automatic gf_st_t gf_digit(input gf_st_t st, input logic [DIGIT_W-1:0] d);
		gf_st_t s;
		int i;
		s = st;
		for (i = DIGIT_W - 1; i >= 0; i--) begin
			if (d[i]) s.acc = s.acc ^ s.v;
			s.v = {1'b0, s.v[BLK_W-1:1]} ^ (s.v[0] ? GF_R : '0);
		end
		return s;
	endfunction

endpackage

// ----- design/ghash_fifo.sv -----
// ghash_fifo: small show-ahead queue of any packed type, used between front and back
// and on the result side. Depends on nothing.

module ghash_fifo #(
	parameter type T     = logic,
	parameter int  DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  T     wr_data,
	output logic full,
	input  logic rd_en,
	output T     rd_data,
	output logic empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	T               mem_q [DEPTH];
	logic [AW-1:0]  wr_ptr_q;
	logic [AW-1:0]  rd_ptr_q;
	logic [CW-1:0]  cnt_q;
	logic           do_wr;
	logic           do_rd;

	assign full    = (cnt_q == FULL_CNT);
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			if (do_rd) rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			if (do_wr && !do_rd) cnt_q <= cnt_q + 1'b1;
			else if (do_rd && !do_wr) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wr_ptr_q] <= wr_data;
	end

endmodule

// ----- design/ghash_front.sv -----
// ghash_front: accepts input transactions and turns each into a work item
// (operand block plus kind). Depends on ghash_pkg.

module ghash_front (
	input  logic             push,
	output logic             full,
	input  ghash_pkg::in_t   item,
	output logic             wq_wr,
	output ghash_pkg::work_t wq_data,
	input  logic             wq_full
);
	import ghash_pkg::*;

	logic [BLK_W-1:0] blk;

	assign full  = wq_full;
	assign wq_wr = push && !wq_full;
	assign blk   = {item.data_hi, item.data_lo};

	always_comb begin
		wq_data.kind    = WK_READ;
		wq_data.operand = blk;
		case (item.cmd)
			CMD_ABSORB: begin
				if (item.byte_count != '0) begin
					wq_data.kind    = WK_MUL_UPD;
					wq_data.operand = blk & byte_mask(item.byte_count);
				end
			end
			CMD_FINAL: begin
				wq_data.kind    = WK_MUL_TAG;
				wq_data.operand = {item.aad_bytes, 3'b000, item.ct_bytes, 3'b000};
			end
			CMD_LOAD: begin
				wq_data.kind = WK_LOAD;
			end
			default: begin
				wq_data.kind = WK_READ;
			end
		endcase
	end

endmodule

// ----- design/ghash_back.sv -----
// ghash_back: holds the running value and executes work items; the GF(2^128)
// multiply is digit-serial, DIGIT_W operand bits a cycle. Depends on ghash_pkg.

module ghash_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [127:0]      key,
	input  logic              work_valid,
	input  ghash_pkg::work_t  work,
	output logic              work_pop,
	input  logic              res_full,
	output logic              res_push,
	output ghash_pkg::out_t   res
);
	import ghash_pkg::*;

	logic              busy_q;
	logic [DIG_CW-1:0] dig_q;
	logic [BLK_W-1:0]  run_q;
	logic [BLK_W-1:0]  x_q;
	gf_st_t            st_q;
	logic              tag_q;
	gf_st_t            st_nxt;
	logic              last;
	logic              is_mul;
	logic              fin;

	assign st_nxt   = gf_digit(st_q, x_q[BLK_W-1 -: DIGIT_W]);
	assign last     = (dig_q == DIG_CW'(DIGITS - 1));
	assign is_mul   = (work.kind == WK_MUL_UPD) || (work.kind == WK_MUL_TAG);
	assign fin      = busy_q && last && !res_full;
	assign work_pop = !busy_q && work_valid && (is_mul || !res_full);
	assign res_push = fin || (!busy_q && work_valid && !is_mul && !res_full);

	always_comb begin
		res.is_tag = 1'b0;
		if (busy_q) begin
			{res.hash_hi, res.hash_lo} = st_nxt.acc;
			res.is_tag                 = tag_q;
		end else if (work.kind == WK_LOAD) begin
			{res.hash_hi, res.hash_lo} = work.operand;
		end else begin
			{res.hash_hi, res.hash_lo} = run_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			dig_q  <= '0;
			run_q  <= '0;
		end else begin
			if (work_pop) begin
				if (is_mul) begin
					busy_q <= 1'b1;
					dig_q  <= '0;
				end else if (work.kind == WK_LOAD) begin
					run_q <= work.operand;
				end
			end else if (busy_q && !last) begin
				dig_q <= dig_q + 1'b1;
			end else if (fin) begin
				busy_q <= 1'b0;
				if (!tag_q) run_q <= st_nxt.acc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (work_pop && is_mul) begin
			x_q    <= run_q ^ work.operand;
			st_q   <= '{acc: '0, v: key};
			tag_q  <= (work.kind == WK_MUL_TAG);
		end else if (busy_q && !last) begin
			x_q  <= {x_q[BLK_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
			st_q <= st_nxt;
		end
	end

endmodule

// ----- design/ghash_gf128_accumulator.sv -----
// ghash_gf128_accumulator: GCM GHASH engine top level with APB key registers.
// Depends on ghash_pkg, ghash_fifo, ghash_front, ghash_back.
//
//  channel  | handshake              | payload
//  ---------+------------------------+----------------------------
//  input    | push / full            | item   (ghash_pkg::in_t)
//  result   | pop / empty            | result (ghash_pkg::out_t)
//  config   | psel penable pwrite    | paddr pwdata prdata, pready
//
// Load, cmd 3 and zero-count absorb are executed directly by the back end, with no multiply.
// Absorb with a nonzero count and finalize load the multiplier, then run the 16 digit steps
// of the 8-bit-per-cycle GF(2^128) multiplier; the last step waits for room in the result queue.
// Inputs are taken while the work queue has room, results wait in the result queue.
// Reset clears the running value, the key and both queues.

module ghash_gf128_accumulator #(
	parameter int WQ_DEPTH = 4,
	parameter int RQ_DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  ghash_pkg::in_t   item,
	output logic             empty,
	input  logic             pop,
	output ghash_pkg::out_t  result,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [3:0]       paddr,
	input  logic [63:0]      pwdata,
	output logic [63:0]      prdata,
	output logic             pready
);
	import ghash_pkg::*;

	logic [63:0] key_hi_q;
	logic [63:0] key_lo_q;
	logic        cfg_wr;

	logic        wq_wr;
	work_t       wq_wdata;
	logic        wq_full;
	logic        wq_empty;
	work_t       wq_rdata;
	logic        work_pop;

	logic        res_push;
	logic        res_full;
	out_t        res_data;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = paddr[3] ? key_lo_q : key_hi_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_hi_q <= '0;
			key_lo_q <= '0;
		end else if (cfg_wr) begin
			if (paddr[3]) key_lo_q <= pwdata;
			else key_hi_q <= pwdata;
		end
	end

	ghash_front u_front (
		.push    (push),
		.full    (full),
		.item    (item),
		.wq_wr   (wq_wr),
		.wq_data (wq_wdata),
		.wq_full (wq_full)
	);

	ghash_fifo #(.T(work_t), .DEPTH(WQ_DEPTH)) u_work_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wq_wr),
		.wr_data (wq_wdata),
		.full    (wq_full),
		.rd_en   (work_pop),
		.rd_data (wq_rdata),
		.empty   (wq_empty)
	);

	ghash_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.key        ({key_hi_q, key_lo_q}),
		.work_valid (!wq_empty),
		.work       (wq_rdata),
		.work_pop   (work_pop),
		.res_full   (res_full),
		.res_push   (res_push),
		.res        (res_data)
	);

	ghash_fifo #(.T(out_t), .DEPTH(RQ_DEPTH)) u_res_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res_data),
		.full    (res_full),
		.rd_en   (pop),
		.rd_data (result),
		.empty   (empty)
	);

`ifndef SYNTHESIS
	a_res_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result pushed into full queue");

	a_pop_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		work_pop |-> !wq_empty)
		else $error("work popped from empty queue");

	a_short_op_result: assert property (@(posedge clk) disable iff (!arst_n)
		(work_pop && (wq_rdata.kind == WK_READ || wq_rdata.kind == WK_LOAD)) |-> res_push)
		else $error("single-cycle work item gave no result");

	a_mul_no_same_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		(work_pop && (wq_rdata.kind == WK_MUL_UPD || wq_rdata.kind == WK_MUL_TAG))
			|=> !res_push)
		else $error("multiply result appeared too early");
`endif

endmodule
